// File: rtl/core/local_branch_entropy_profiler_assert.svh
// ----------------------------------------------------------------------------
// local branch entropy profiler assertion macros
// concurrent checks sampled on clk, idle while rst_n is low
// ----------------------------------------------------------------------------
`ifndef LOCAL_BRANCH_ENTROPY_PROFILER_ASSERT_SVH
`define LOCAL_BRANCH_ENTROPY_PROFILER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// implication property checked on every clock outside reset
`define LBEP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// plain invariant checked on every clock outside reset
`define LBEP_INVARIANT(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`else

`define LBEP_ASSERT(lbl, prop, msg)

`define LBEP_INVARIANT(lbl, expr, msg)

`endif

`endif

// File: rtl/core/lbep_pkg.sv
// ----------------------------------------------------------------------------
// lbep_pkg
// shared widths, defaults and register indexes of the branch entropy profiler
// ----------------------------------------------------------------------------
package lbep_pkg;

    localparam int PC_BITS             = 48;
    localparam int SUM_BITS            = 48;
    localparam int ADDR_BITS_W         = 3;
    localparam int HIST_BITS_W         = 4;
    localparam int CFG_INDEX_BITS      = 2;
    localparam int CFG_DATA_BITS       = 4;

    localparam int PC_INDEX_BITS_DEF   = 6;
    localparam int HISTORY_MAX_DEF     = 10;
    localparam int COUNTER_BITS_DEF    = 32;

    localparam logic [ADDR_BITS_W-1:0] ADDR_BITS_RST = 3'd6;
    localparam logic [HIST_BITS_W-1:0] HIST_BITS_RST = 4'd10;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ADDR_BITS = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HIST_BITS = 2'd1;

endpackage

// File: rtl/core/lbep_branch_if.sv
// ----------------------------------------------------------------------------
// lbep_branch_if
// valid/ready channel carrying one resolved conditional branch
// ----------------------------------------------------------------------------
interface lbep_branch_if import lbep_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [PC_BITS-1:0] branch_pc;
    logic               was_taken;

    modport source (output valid, output branch_pc, output was_taken, input ready);
    modport sink   (input valid, input branch_pc, input was_taken, output ready);

endinterface

// File: rtl/core/lbep_result_if.sv
// ----------------------------------------------------------------------------
// lbep_result_if
// valid/ready channel carrying the running sums after one branch
// ----------------------------------------------------------------------------
interface lbep_result_if import lbep_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [SUM_BITS-1:0] entropy_sum;
    logic [SUM_BITS-1:0] branch_count;
    logic                saturated;

    modport source (
        output valid, output entropy_sum, output branch_count, output saturated,
        input  ready
    );
    modport sink (
        input  valid, input entropy_sum, input branch_count, input saturated,
        output ready
    );

endinterface

// File: rtl/core/lbep_cfg_if.sv
// ----------------------------------------------------------------------------
// lbep_cfg_if
// valid/ready register write channel
// ----------------------------------------------------------------------------
interface lbep_cfg_if import lbep_pkg::*; ();

    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);

endinterface

// File: rtl/core/local_branch_entropy_profiler.sv
// ----------------------------------------------------------------------------
// local_branch_entropy_profiler
// linear branch entropy counters over local history buckets
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the counter table, one entry
// a cycle, over all 2^(PC_INDEX_BITS+HISTORY_MAX) entries (65536 at the defaults);
// no branch word is taken until it ends, register writes are taken throughout.
// Each branch passes the back end's steps in order (history read, counter read,
// update and result), one branch at a time; the front and its two-entry queue
// accept words while earlier ones are in work, and a result word waiting in the
// output register holds the next branch at its update step until it is taken.
// Linear entropy is entropy_sum / branch_count.
module local_branch_entropy_profiler import lbep_pkg::*; #(
    parameter int PC_INDEX_BITS = PC_INDEX_BITS_DEF,
    parameter int HISTORY_MAX   = HISTORY_MAX_DEF,
    parameter int COUNTER_BITS  = COUNTER_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    lbep_cfg_if.sink      cfg,
    lbep_branch_if.sink   branch,
    lbep_result_if.source result
);

    localparam int ENTRY_W = 2 * PC_INDEX_BITS + HISTORY_MAX + 1;

    logic               clearing;
    logic               q_full;
    logic               q_push;
    logic [ENTRY_W-1:0] q_push_data;
    logic               q_pop;
    logic               q_valid;
    logic [ENTRY_W-1:0] q_data;

    lbep_front #(
        .PC_INDEX_BITS (PC_INDEX_BITS),
        .HISTORY_MAX   (HISTORY_MAX),
        .ENTRY_W       (ENTRY_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .branch      (branch),
        .clearing    (clearing),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_push_data (q_push_data)
    );

    lbep_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .data      (q_data)
    );

    lbep_back #(
        .PC_INDEX_BITS (PC_INDEX_BITS),
        .HISTORY_MAX   (HISTORY_MAX),
        .COUNTER_BITS  (COUNTER_BITS),
        .ENTRY_W       (ENTRY_W)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .clearing (clearing),
        .result   (result)
    );

endmodule

// File: rtl/core/lbep_ram.sv
// ----------------------------------------------------------------------------
// lbep_ram
// generic single write port, single read port memory with registered read
// ----------------------------------------------------------------------------
module lbep_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/core/lbep_front.sv
// ----------------------------------------------------------------------------
// lbep_front
// holds the bucket registers, takes branch words and masks them into queue entries
// ----------------------------------------------------------------------------
module lbep_front import lbep_pkg::*; #(
    parameter int PC_INDEX_BITS = PC_INDEX_BITS_DEF,
    parameter int HISTORY_MAX   = HISTORY_MAX_DEF,
    parameter int ENTRY_W       = 2 * PC_INDEX_BITS + HISTORY_MAX + 1
) (
    input  logic               clk,
    input  logic               rst_n,
    lbep_cfg_if.sink           cfg,
    lbep_branch_if.sink        branch,
    input  logic               clearing,
    input  logic               q_full,
    output logic               q_push,
    output logic [ENTRY_W-1:0] q_push_data
);

    logic [ADDR_BITS_W-1:0]   addr_bits_reg;
    logic [HIST_BITS_W-1:0]   hist_bits_reg;
    logic [PC_INDEX_BITS-1:0] pc_masked;
    logic [HISTORY_MAX-1:0]   hist_mask;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_bits_reg <= ADDR_BITS_RST;
            hist_bits_reg <= HIST_BITS_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_ADDR_BITS: addr_bits_reg <= cfg.data[ADDR_BITS_W-1:0];
                CFG_HIST_BITS: hist_bits_reg <= cfg.data[HIST_BITS_W-1:0];
                default:       ;
            endcase
        end
    end

    // settings wider than the tables keep every bit
    always_comb
    begin
        for (int i = 0; i < PC_INDEX_BITS; i++)
        begin
            pc_masked[i] = branch.branch_pc[i] & (int'(addr_bits_reg) > i);
        end
        for (int i = 0; i < HISTORY_MAX; i++)
        begin
            hist_mask[i] = int'(hist_bits_reg) > i;
        end
    end

    assign branch.ready = !q_full && !clearing;
    assign q_push       = branch.valid && branch.ready;
    assign q_push_data  = {branch.branch_pc[PC_INDEX_BITS-1:0], pc_masked, hist_mask,
                           branch.was_taken};

endmodule

// File: rtl/core/lbep_queue.sv
// ----------------------------------------------------------------------------
// lbep_queue
// two-entry fifo between the front and the back
// ----------------------------------------------------------------------------
module lbep_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             valid,
    output logic [WIDTH-1:0] data
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;

    assign full  = count_reg == 2'd2;
    assign valid = count_reg != 2'd0;
    assign data  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// File: rtl/core/lbep_back.sv
// ----------------------------------------------------------------------------
// lbep_back
// history and counter table update, running sums and result register
// ----------------------------------------------------------------------------
module lbep_back import lbep_pkg::*; #(
    parameter int PC_INDEX_BITS = PC_INDEX_BITS_DEF,
    parameter int HISTORY_MAX   = HISTORY_MAX_DEF,
    parameter int COUNTER_BITS  = COUNTER_BITS_DEF,
    parameter int ENTRY_W       = 2 * PC_INDEX_BITS + HISTORY_MAX + 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  logic [ENTRY_W-1:0] q_data,
    output logic               q_pop,
    output logic               clearing,
    lbep_result_if.source      result
);

`include "local_branch_entropy_profiler_assert.svh"

    localparam int BUCKET_BITS = PC_INDEX_BITS + HISTORY_MAX;
    localparam int CTR_W       = 2 * COUNTER_BITS;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HIST,
        ST_CTR
    } state_t;

    state_t                   state_reg;
    logic [BUCKET_BITS-1:0]   clr_addr_reg;
    logic [PC_INDEX_BITS-1:0] hidx_reg;
    logic [PC_INDEX_BITS-1:0] pcm_reg;
    logic [HISTORY_MAX-1:0]   hmask_reg;
    logic                     taken_reg;
    logic [SUM_BITS-1:0]      min_sum_reg;
    logic [SUM_BITS-1:0]      total_reg;
    logic                     out_valid_reg;
    logic [SUM_BITS-1:0]      out_sum_reg;
    logic [SUM_BITS-1:0]      out_count_reg;
    logic                     out_sat_reg;

    logic [HISTORY_MAX-1:0]   hist_rd;
    logic [HISTORY_MAX-1:0]   hist_next;
    logic [BUCKET_BITS-1:0]   bucket;
    logic [CTR_W-1:0]         ctr_rd;
    logic [CTR_W-1:0]         ctr_next;
    logic [COUNTER_BITS-1:0]  mine;
    logic [COUNTER_BITS-1:0]  other;
    logic [COUNTER_BITS-1:0]  mine_inc;
    logic [SUM_BITS-1:0]      min_sum_next;
    logic                     sat;
    logic                     fire;
    logic                     update;
    logic                     hist_we;
    logic [PC_INDEX_BITS-1:0] hist_waddr;
    logic [HISTORY_MAX-1:0]   hist_wdata;
    logic                     ctr_we;
    logic [BUCKET_BITS-1:0]   ctr_waddr;
    logic [CTR_W-1:0]         ctr_wdata;

    assign clearing = state_reg == ST_CLEAR;
    assign q_pop    = (state_reg == ST_IDLE) && q_valid;

    // history read address comes straight from the queue head
    lbep_ram #(
        .WIDTH (HISTORY_MAX),
        .DEPTH (2 ** PC_INDEX_BITS)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .re    (q_pop),
        .raddr (q_data[ENTRY_W-1 -: PC_INDEX_BITS]),
        .rdata (hist_rd)
    );

    // entry layout: taken counter high, not-taken counter low
    lbep_ram #(
        .WIDTH (CTR_W),
        .DEPTH (2 ** BUCKET_BITS)
    ) u_ctr_ram (
        .clk   (clk),
        .we    (ctr_we),
        .waddr (ctr_waddr),
        .wdata (ctr_wdata),
        .re    (state_reg == ST_HIST),
        .raddr (bucket),
        .rdata (ctr_rd)
    );

    assign bucket       = {pcm_reg, hist_rd & hmask_reg};
    assign mine         = taken_reg ? ctr_rd[CTR_W-1:COUNTER_BITS] : ctr_rd[COUNTER_BITS-1:0];
    assign other        = taken_reg ? ctr_rd[COUNTER_BITS-1:0] : ctr_rd[CTR_W-1:COUNTER_BITS];
    assign mine_inc     = mine + COUNTER_BITS'(1);
    assign ctr_next     = taken_reg ? {mine_inc, other} : {other, mine_inc};
    assign sat          = (&mine) || (&total_reg);
    assign min_sum_next = (mine < other) ? min_sum_reg + SUM_BITS'(2) : min_sum_reg;
    assign hist_next    = HISTORY_MAX'({hist_rd, taken_reg});

    assign fire   = (state_reg == ST_CTR) && (!out_valid_reg || result.ready);
    assign update = fire && !sat;

    // the clearing pass writes zeros to both tables at once
    assign hist_we    = clearing || update;
    assign hist_waddr = clearing ? clr_addr_reg[PC_INDEX_BITS-1:0] : hidx_reg;
    assign hist_wdata = clearing ? '0 : hist_next;
    assign ctr_we     = clearing || update;
    assign ctr_waddr  = clearing ? clr_addr_reg : bucket;
    assign ctr_wdata  = clearing ? '0 : ctr_next;

    assign result.valid        = out_valid_reg;
    assign result.entropy_sum  = out_sum_reg;
    assign result.branch_count = out_count_reg;
    assign result.saturated    = out_sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            hidx_reg      <= '0;
            pcm_reg       <= '0;
            hmask_reg     <= '0;
            taken_reg     <= 1'b0;
            min_sum_reg   <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_sum_reg   <= '0;
            out_count_reg <= '0;
            out_sat_reg   <= 1'b0;
        end
        else
        begin
            if (result.ready && !fire)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + BUCKET_BITS'(1);
                    if (&clr_addr_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        {hidx_reg, pcm_reg, hmask_reg, taken_reg} <= q_data;
                        state_reg <= ST_HIST;
                    end
                end
                ST_HIST:
                begin
                    state_reg <= ST_CTR;
                end
                ST_CTR:
                begin
                    if (fire)
                    begin
                        out_valid_reg <= 1'b1;
                        out_sat_reg   <= sat;
                        if (sat)
                        begin
                            out_sum_reg   <= min_sum_reg;
                            out_count_reg <= total_reg;
                        end
                        else
                        begin
                            min_sum_reg   <= min_sum_next;
                            total_reg     <= total_reg + SUM_BITS'(1);
                            out_sum_reg   <= min_sum_next;
                            out_count_reg <= total_reg + SUM_BITS'(1);
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `LBEP_ASSERT(a_no_pop_in_clear, clearing |-> !q_pop, "queue popped during clearing pass")
    `LBEP_INVARIANT(a_sum_below_count, min_sum_reg <= total_reg, "entropy sum above branch count")
    `LBEP_ASSERT(a_sat_holds_sums, (fire && sat) |=> (min_sum_reg == $past(min_sum_reg)
        && total_reg == $past(total_reg)), "dropped branch changed the sums")
    `LBEP_ASSERT(a_result_after_update, $rose(out_valid_reg) |-> $past(state_reg) == ST_CTR,
        "result raised outside the update step")

endmodule
